// ===== design/bfifo_pkg.sv =====
// Shared constants, codes and payload types of the block ring FIFO.
package bfifo_pkg;

  localparam int MAX_BLOCK_SIZE = 64;
  localparam int MAX_BLOCKS     = 16;
  localparam int SAMPLE_WIDTH   = 16;

  localparam int OFF_W   = $clog2(MAX_BLOCK_SIZE);
  localparam int SLOT_W  = $clog2(MAX_BLOCKS);
  localparam int ADDR_W  = SLOT_W + OFF_W;
  localparam int DEPTH   = MAX_BLOCKS * MAX_BLOCK_SIZE;

  // Configuration register widths and indexes.
  localparam int BS_W    = 7;
  localparam int NB_W    = 5;
  localparam int CFG_W   = 7;
  localparam int CIDX_W  = 1;
  localparam logic [CIDX_W-1:0] REG_BLOCK_SIZE = 1'd0;
  localparam logic [CIDX_W-1:0] REG_NUM_BLOCKS = 1'd1;
  localparam logic [BS_W-1:0]   BLOCK_SIZE_RST = 7'd64;
  localparam logic [NB_W-1:0]   NUM_BLOCKS_RST = 5'd16;

  // Operation codes.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_PEEK  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // Result kinds.
  localparam logic [2:0] KIND_STORED  = 3'd0;
  localparam logic [2:0] KIND_DROPPED = 3'd1;
  localparam logic [2:0] KIND_ELEMENT = 3'd2;
  localparam logic [2:0] KIND_EMPTY   = 3'd3;
  localparam logic [2:0] KIND_CLEARED = 3'd4;

  typedef struct packed {
    logic [1:0]              op;
    logic [SAMPLE_WIDTH-1:0] sample;
  } in_t;

  typedef struct packed {
    logic [2:0]              kind;
    logic [SAMPLE_WIDTH-1:0] element;
    logic [5:0]              element_index;
    logic                    last;
    logic                    committed;
    logic                    full_flag;
    logic                    empty_flag;
  } out_t;

endpackage

// ===== design/bfifo_ram.sv =====
// Simple dual-port synchronous RAM with a registered read port.
module bfifo_ram #(
  parameter int DATA_W = 16,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [(1 << ADDR_W)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/bfifo_outq.sv =====
// Two-entry result queue that decouples the result stream from the consumer.
module bfifo_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bfifo_pkg::out_t  push_data,
  input  logic             pop,
  output logic             valid,
  output bfifo_pkg::out_t  head,
  output logic [1:0]       count
);

  bfifo_pkg::out_t e0, e1;
  bfifo_pkg::out_t e0_next, e1_next;
  logic [1:0]      count_next;
  logic [1:0]      kept;

  always_comb begin
    e0_next = e0;
    e1_next = e1;
    kept    = count;
    if (pop) begin
      e0_next = e1;
      kept    = count - 2'd1;
    end
    if (push) begin
      if (kept == 2'd0) begin
        e0_next = push_data;
      end else begin
        e1_next = push_data;
      end
    end
    count_next = kept + {1'b0, push};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    e0 <= e0_next;
    e1 <= e1_next;
  end

  assign valid = (count != 2'd0);
  assign head  = e0;

endmodule

// ===== design/block_ring_fifo.sv =====
// Top level of the block ring FIFO: slot pointers, write and read sequencing, result staging.
//
// A ring of num_blocks slots (up to 16), each holding block_size 16-bit elements (up to 64),
// kept in one 1024-entry RAM addressed by slot and element offset. Write, clear and a read or
// peek of an empty ring each give one result. A read or peek of a non-empty ring is accepted
// and then streams block_size element results from the RAM read port, one per cycle while the
// output queue has room; no new transfer is taken while a block is streaming. Every result
// passes through a register stage (pend) that matches the RAM read latency and then a
// two-entry output queue, so a result is registered in that stage and then in the queue before
// it appears on the output, and a new item is taken while earlier results still wait in the
// queue. A stalled consumer holds the stream back without losing elements. The pointers and
// flags change at the transfer of an item, and the full and empty flags in each result show
// the state after that item. Store entries that were never written read back as arbitrary
// data. The user must write configuration only while the block is idle; the block itself
// does not enforce this.
module block_ring_fifo (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  bfifo_pkg::in_t                     in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output bfifo_pkg::out_t                    out_data,
  input  logic                               cfg_we,
  input  logic [bfifo_pkg::CIDX_W-1:0]       cfg_index,
  input  logic [bfifo_pkg::CFG_W-1:0]        cfg_data
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_STREAM = 1'b1;

  // Configuration registers.
  logic [bfifo_pkg::BS_W-1:0] block_size;
  logic [bfifo_pkg::NB_W-1:0] num_blocks;

  // Ring state.
  logic [bfifo_pkg::SLOT_W-1:0] write_slot, write_slot_next;
  logic [bfifo_pkg::SLOT_W-1:0] read_slot, read_slot_next;
  logic                         full, full_next;
  logic [bfifo_pkg::OFF_W-1:0]  write_offset, write_offset_next;
  logic                         dropping, dropping_next;

  // Block streaming sequencer.
  logic                         state, state_next;
  logic [bfifo_pkg::SLOT_W-1:0] rd_slot, rd_slot_next;
  logic [bfifo_pkg::OFF_W-1:0]  idx, idx_next;
  logic [bfifo_pkg::BS_W-1:0]   bs_lat, bs_lat_next;

  // Result stage aligned with the RAM read latency.
  logic            pend_valid;
  logic            pend_from_ram;
  bfifo_pkg::out_t pend;
  logic            issue;
  logic            issue_from_ram;
  bfifo_pkg::out_t issue_res;

  // RAM ports.
  logic                               ram_we, ram_re;
  logic [bfifo_pkg::ADDR_W-1:0]       ram_waddr, ram_raddr;
  logic [bfifo_pkg::SAMPLE_WIDTH-1:0] ram_rdata;

  // Output queue.
  logic            q_push, q_pop;
  bfifo_pkg::out_t q_in;
  logic [1:0]      q_count;
  logic [1:0]      occ;
  logic            can_issue;

  logic [bfifo_pkg::BS_W-1:0] bs_eff;
  logic [bfifo_pkg::NB_W-1:0] nb_eff;
  logic                       accept;
  logic                       empty_now;
  logic                       last_elem;
  logic                       drop_now;
  logic                       committed;
  logic                       stream_last;

  // Slot after s, wrapping at the slot count in use.
  function automatic logic [bfifo_pkg::SLOT_W-1:0] next_slot(
    input logic [bfifo_pkg::SLOT_W-1:0] s,
    input logic [bfifo_pkg::NB_W-1:0]   nb
  );
    logic [bfifo_pkg::SLOT_W:0] n;
    n = {1'b0, s} + {{bfifo_pkg::SLOT_W{1'b0}}, 1'b1};
    if (bfifo_pkg::NB_W'(n) >= nb) begin
      return '0;
    end
    return n[bfifo_pkg::SLOT_W-1:0];
  endfunction

  // Out-of-range register values are clamped to the legal range.
  always_comb begin
    if (block_size == '0) begin
      bs_eff = bfifo_pkg::BS_W'(1);
    end else if (block_size > bfifo_pkg::BS_W'(bfifo_pkg::MAX_BLOCK_SIZE)) begin
      bs_eff = bfifo_pkg::BS_W'(bfifo_pkg::MAX_BLOCK_SIZE);
    end else begin
      bs_eff = block_size;
    end
    if (num_blocks == '0) begin
      nb_eff = bfifo_pkg::NB_W'(1);
    end else if (num_blocks > bfifo_pkg::NB_W'(bfifo_pkg::MAX_BLOCKS)) begin
      nb_eff = bfifo_pkg::NB_W'(bfifo_pkg::MAX_BLOCKS);
    end else begin
      nb_eff = num_blocks;
    end
  end

  // The queue plus the result in flight never exceed two entries, so a result may be
  // issued whenever that total, less any transfer leaving this cycle, is below two.
  assign q_pop     = out_valid && out_ready;
  assign occ       = q_count + {1'b0, pend_valid};
  assign can_issue = (occ < 2'd2) || q_pop;
  assign in_ready  = (state == ST_IDLE) && can_issue;
  assign accept    = in_valid && in_ready;
  assign empty_now = !full && (read_slot == write_slot);

  // A write is the last of its block once the offset reaches block_size - 1, even if
  // block_size was lowered while the block was partly written.
  assign last_elem   = ({1'b0, write_offset} + bfifo_pkg::BS_W'(1)) >= bs_eff;
  assign drop_now    = (write_offset == '0) ? full : dropping;
  assign stream_last = ({1'b0, idx} + bfifo_pkg::BS_W'(1)) == bs_lat;

  always_comb begin
    write_slot_next   = write_slot;
    read_slot_next    = read_slot;
    full_next         = full;
    write_offset_next = write_offset;
    dropping_next     = dropping;
    state_next        = state;
    rd_slot_next      = rd_slot;
    idx_next          = idx;
    bs_lat_next       = bs_lat;
    committed         = 1'b0;
    issue             = 1'b0;
    issue_from_ram    = 1'b0;
    issue_res         = '0;
    ram_we            = 1'b0;
    ram_waddr         = {write_slot, write_offset};
    ram_re            = 1'b0;
    ram_raddr         = {rd_slot, idx};

    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.op)
            bfifo_pkg::OP_WRITE: begin
              if (!drop_now) begin
                ram_we = 1'b1;
                if (last_elem) begin
                  write_slot_next = next_slot(write_slot, nb_eff);
                  if (write_slot_next == read_slot) begin
                    full_next = 1'b1;
                  end
                  committed = 1'b1;
                end
              end
              if (last_elem) begin
                write_offset_next = '0;
                dropping_next     = 1'b0;
              end else begin
                write_offset_next = write_offset + bfifo_pkg::OFF_W'(1);
                dropping_next     = drop_now;
              end
              issue                   = 1'b1;
              issue_res.kind          = drop_now ? bfifo_pkg::KIND_DROPPED
                                                 : bfifo_pkg::KIND_STORED;
              issue_res.element_index = 6'(write_offset);
              issue_res.last          = 1'b1;
              issue_res.committed     = committed;
              issue_res.full_flag     = full_next;
              issue_res.empty_flag    = !full_next && (read_slot == write_slot_next);
            end
            bfifo_pkg::OP_READ, bfifo_pkg::OP_PEEK: begin
              if (empty_now) begin
                issue                = 1'b1;
                issue_res.kind       = bfifo_pkg::KIND_EMPTY;
                issue_res.last       = 1'b1;
                issue_res.full_flag  = full;
                issue_res.empty_flag = 1'b1;
              end else begin
                // The block is streamed from the slot held here; a read also moves the read pointer now.
                rd_slot_next = read_slot;
                idx_next     = '0;
                bs_lat_next  = bs_eff;
                state_next   = ST_STREAM;
                if (in_data.op == bfifo_pkg::OP_READ) begin
                  read_slot_next = next_slot(read_slot, nb_eff);
                  full_next      = 1'b0;
                end
              end
            end
            bfifo_pkg::OP_CLEAR: begin
              write_slot_next      = '0;
              read_slot_next       = '0;
              full_next            = 1'b0;
              write_offset_next    = '0;
              dropping_next        = 1'b0;
              issue                = 1'b1;
              issue_res.kind       = bfifo_pkg::KIND_CLEARED;
              issue_res.last       = 1'b1;
              issue_res.empty_flag = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_STREAM: begin
        if (can_issue) begin
          issue                   = 1'b1;
          issue_from_ram          = 1'b1;
          ram_re                  = 1'b1;
          issue_res.kind          = bfifo_pkg::KIND_ELEMENT;
          issue_res.element_index = 6'(idx);
          issue_res.last          = stream_last;
          issue_res.full_flag     = full;
          issue_res.empty_flag    = empty_now;
          idx_next                = idx + bfifo_pkg::OFF_W'(1);
          if (stream_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size   <= bfifo_pkg::BLOCK_SIZE_RST;
      num_blocks   <= bfifo_pkg::NUM_BLOCKS_RST;
      write_slot   <= '0;
      read_slot    <= '0;
      full         <= 1'b0;
      write_offset <= '0;
      dropping     <= 1'b0;
      state        <= ST_IDLE;
      pend_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bfifo_pkg::REG_BLOCK_SIZE: block_size <= cfg_data[bfifo_pkg::BS_W-1:0];
          bfifo_pkg::REG_NUM_BLOCKS: num_blocks <= cfg_data[bfifo_pkg::NB_W-1:0];
          default: begin
          end
        endcase
      end
      write_slot   <= write_slot_next;
      read_slot    <= read_slot_next;
      full         <= full_next;
      write_offset <= write_offset_next;
      dropping     <= dropping_next;
      state        <= state_next;
      pend_valid   <= issue;
    end
  end

  always_ff @(posedge clk) begin
    rd_slot       <= rd_slot_next;
    idx           <= idx_next;
    bs_lat        <= bs_lat_next;
    pend          <= issue_res;
    pend_from_ram <= issue_from_ram;
  end

  // The element value joins its result as the RAM data arrives.
  always_comb begin
    q_in = pend;
    if (pend_from_ram) begin
      q_in.element = ram_rdata;
    end
  end
  assign q_push = pend_valid;

  bfifo_ram #(
    .DATA_W(bfifo_pkg::SAMPLE_WIDTH),
    .ADDR_W(bfifo_pkg::ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_data.sample),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bfifo_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .valid     (out_valid),
    .head      (out_data),
    .count     (q_count)
  );

endmodule
